// ----- sv/gcrb_pkg.sv -----
// gcrb_pkg: shared types, codes and reset values for the rotary/button event decoder.
// No dependencies; every other file takes names from here by scope.
package gcrb_pkg;

  localparam int unsigned SnapW  = 16;
  localparam int unsigned PinW   = 4;
  localparam int unsigned KindW  = 2;
  localparam int unsigned StepW  = 2;
  localparam int unsigned CfgAW  = 4;
  localparam int unsigned CfgDW  = 32;

  typedef logic [KindW-1:0] kind_t;

  localparam kind_t KIND_ROTARY  = 2'd0;
  localparam kind_t KIND_PRESS   = 2'd1;
  localparam kind_t KIND_RELEASE = 2'd2;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_A_PIN = 2'd0;
  localparam reg_idx_t REG_B_PIN = 2'd1;
  localparam reg_idx_t REG_TABLE = 2'd2;

  localparam logic [PinW-1:0]  A_PIN_RST = 4'd0;
  localparam logic [PinW-1:0]  B_PIN_RST = 4'd1;
  localparam logic [CfgDW-1:0] TABLE_RST = 32'h3443_C11C;
  localparam logic [SnapW-1:0] SNAP_RST  = 16'hFFFF;

endpackage

// ----- sv/gcrb_in_if.sv -----
// gcrb_in_if: valid/ready channel that carries one pin snapshot item.
// Depends on gcrb_pkg for the field width.
interface gcrb_in_if;
  logic                           valid;
  logic                           ready;
  logic [gcrb_pkg::SnapW-1:0]     pin_snapshot;

  modport source (output valid, output pin_snapshot, input ready);
  modport sink   (input valid, input pin_snapshot, output ready);
endinterface

// ----- sv/gcrb_out_if.sv -----
// gcrb_out_if: valid/ready channel that carries one decoded event item.
// Depends on gcrb_pkg for field widths.
interface gcrb_out_if;
  logic                           valid;
  logic                           ready;
  logic [gcrb_pkg::KindW-1:0]     event_kind;
  logic [gcrb_pkg::PinW-1:0]      pin_index;
  logic signed [gcrb_pkg::StepW-1:0] rotary_step;
  logic                           last_event;

  modport source (output valid, output event_kind, output pin_index,
                  output rotary_step, output last_event, input ready);
  modport sink   (input valid, input event_kind, input pin_index,
                  input rotary_step, input last_event, output ready);
endinterface

// ----- sv/gpio_change_rotary_button_events_top.sv -----
// gpio_change_rotary_button_events_top: snapshot change decoder, rotary step then button events.
// Depends on gcrb_pkg, gcrb_in_if and gcrb_out_if.
//
//   channel   dir  handshake            payload
//   in_item   in   valid/ready          pin_snapshot
//   out_item  out  valid/ready          event_kind, pin_index, rotary_step, last_event
//   cfg_*     in   APB write/read       encoder A pin, encoder B pin, step table
//
// One snapshot goes through the rotary lookup, then a scan of one pin per cycle up to the
// highest changed non-rotary pin, set by the scan counter; a stalled sink pauses either step.
// Each emitted event waits in the output register; a stalled sink holds the sequencer.
// in_item.ready is high only while idle; the next item is taken once the last event is loaded.
// Reset: previous snapshot all ones, previous AB zero, registers to their defaults.
module gpio_change_rotary_button_events_top (
  input  logic                          clk,
  input  logic                          rst_n,
  gcrb_in_if.sink                       in_item,
  gcrb_out_if.source                    out_item,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [gcrb_pkg::CfgAW-1:0]    cfg_paddr,
  input  logic [gcrb_pkg::CfgDW-1:0]    cfg_pwdata,
  output logic [gcrb_pkg::CfgDW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  typedef enum logic [1:0] {S_IDLE, S_ROT, S_SCAN} state_t;

  state_t                          state_r, state_nxt;
  logic [gcrb_pkg::SnapW-1:0]      now_r, now_nxt;
  logic [gcrb_pkg::SnapW-1:0]      changed_r, changed_nxt;
  logic [gcrb_pkg::SnapW-1:0]      prev_snap_r, prev_snap_nxt;
  logic [1:0]                      prev_ab_r, prev_ab_nxt;
  logic [gcrb_pkg::PinW-1:0]       pin_r, pin_nxt;

  logic                            out_valid_r, out_valid_nxt;
  gcrb_pkg::kind_t                 out_kind_r, out_kind_nxt;
  logic [gcrb_pkg::PinW-1:0]       out_pin_r, out_pin_nxt;
  logic [gcrb_pkg::StepW-1:0]      out_step_r, out_step_nxt;
  logic                            out_last_r, out_last_nxt;

  logic [gcrb_pkg::PinW-1:0]       a_pin_r;
  logic [gcrb_pkg::PinW-1:0]       b_pin_r;
  logic [gcrb_pkg::CfgDW-1:0]      table_r;

  logic                            out_free;
  logic [gcrb_pkg::SnapW-1:0]      rmask;
  logic [gcrb_pkg::SnapW-1:0]      rest;
  logic                            rot_hit;
  logic [1:0]                      cur_ab;
  logic [3:0]                      tbl_idx;
  logic [gcrb_pkg::StepW-1:0]      step;
  logic                            pin_hit;
  logic [gcrb_pkg::SnapW-1:0]      scan_rest;
  logic                            cfg_wr;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_pin_r <= gcrb_pkg::A_PIN_RST;
      b_pin_r <= gcrb_pkg::B_PIN_RST;
      table_r <= gcrb_pkg::TABLE_RST;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      case (cfg_paddr[3:2])
        gcrb_pkg::REG_A_PIN: a_pin_r <= cfg_pwdata[gcrb_pkg::PinW-1:0];
        gcrb_pkg::REG_B_PIN: b_pin_r <= cfg_pwdata[gcrb_pkg::PinW-1:0];
        gcrb_pkg::REG_TABLE: table_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      gcrb_pkg::REG_A_PIN: cfg_prdata = {{(gcrb_pkg::CfgDW-gcrb_pkg::PinW){1'b0}}, a_pin_r};
      gcrb_pkg::REG_B_PIN: cfg_prdata = {{(gcrb_pkg::CfgDW-gcrb_pkg::PinW){1'b0}}, b_pin_r};
      gcrb_pkg::REG_TABLE: cfg_prdata = table_r;
      default:             cfg_prdata = '0;
    endcase
  end

  // shared decode for the current step
  assign out_free  = !out_valid_r || out_item.ready;
  assign rmask     = (16'd1 << a_pin_r) | (16'd1 << b_pin_r);
  assign rest      = changed_r & ~rmask;
  assign rot_hit   = (changed_r & rmask) != '0;
  assign cur_ab    = {~now_r[a_pin_r], ~now_r[b_pin_r]};
  assign tbl_idx   = {prev_ab_r, cur_ab};
  assign step      = table_r[{tbl_idx, 1'b0} +: 2];
  assign pin_hit   = changed_r[pin_r];
  assign scan_rest = changed_r & ~(16'd1 << pin_r);

  assign in_item.ready        = (state_r == S_IDLE);
  assign out_item.valid       = out_valid_r;
  assign out_item.event_kind  = out_kind_r;
  assign out_item.pin_index   = out_pin_r;
  assign out_item.rotary_step = out_step_r;
  assign out_item.last_event  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    changed_nxt   = changed_r;
    prev_snap_nxt = prev_snap_r;
    prev_ab_nxt   = prev_ab_r;
    pin_nxt       = pin_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    out_kind_nxt  = out_kind_r;
    out_pin_nxt   = out_pin_r;
    out_step_nxt  = out_step_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_item.valid) begin
          now_nxt       = in_item.pin_snapshot;
          changed_nxt   = in_item.pin_snapshot ^ prev_snap_r;
          prev_snap_nxt = in_item.pin_snapshot;
          state_nxt     = S_ROT;
        end
      end
      S_ROT: begin
        if (!rot_hit) begin
          pin_nxt   = '0;
          state_nxt = (changed_r == '0) ? S_IDLE : S_SCAN;
        end else if (step == '0 || out_free) begin
          if (step != '0) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = gcrb_pkg::KIND_ROTARY;
            out_pin_nxt   = '0;
            out_step_nxt  = step;
            out_last_nxt  = (rest == '0);
          end
          prev_ab_nxt = cur_ab;
          changed_nxt = rest;
          pin_nxt     = '0;
          state_nxt   = (rest == '0) ? S_IDLE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (!pin_hit || out_free) begin
          if (pin_hit) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = now_r[pin_r] ? gcrb_pkg::KIND_RELEASE : gcrb_pkg::KIND_PRESS;
            out_pin_nxt   = pin_r;
            out_step_nxt  = '0;
            out_last_nxt  = (scan_rest == '0);
          end
          changed_nxt = scan_rest;
          pin_nxt     = pin_r + 4'd1;
          if (scan_rest == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_snap_r <= gcrb_pkg::SNAP_RST;
      prev_ab_r   <= 2'b00;
      out_valid_r <= 1'b0;
      changed_r   <= '0;
      pin_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      prev_snap_r <= prev_snap_nxt;
      prev_ab_r   <= prev_ab_nxt;
      out_valid_r <= out_valid_nxt;
      changed_r   <= changed_nxt;
      pin_r       <= pin_nxt;
    end
    now_r      <= now_nxt;
    out_kind_r <= out_kind_nxt;
    out_pin_r  <= out_pin_nxt;
    out_step_r <= out_step_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ----- sv/gcrb_checker.sv -----
// gcrb_checker: port-level assertions for the event decoder, bound to the top level.
// Depends on gcrb_pkg and gpio_change_rotary_button_events_top.
module gcrb_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [gcrb_pkg::KindW-1:0]        out_kind,
  input logic [gcrb_pkg::PinW-1:0]         out_pin,
  input logic [gcrb_pkg::StepW-1:0]        out_step,
  input logic                              out_last
);

  // busy while a non-final event of the current snapshot is pending
  a_busy_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready while a non-final event is pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_pin)
      && $stable(out_step) && $stable(out_last))
    else $error("stalled event changed");

  a_rotary_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == gcrb_pkg::KIND_ROTARY |-> out_pin == '0 && out_step != '0)
    else $error("malformed rotary event");

  a_button_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != gcrb_pkg::KIND_ROTARY |->
      out_step == '0 && (out_kind == gcrb_pkg::KIND_PRESS
                         || out_kind == gcrb_pkg::KIND_RELEASE))
    else $error("malformed button event");

endmodule

bind gpio_change_rotary_button_events_top gcrb_checker u_gcrb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_item.valid),
  .in_ready  (in_item.ready),
  .out_valid (out_item.valid),
  .out_ready (out_item.ready),
  .out_kind  (out_item.event_kind),
  .out_pin   (out_item.pin_index),
  .out_step  (out_item.rotary_step),
  .out_last  (out_item.last_event)
);
